FILE: sv/vpt_pkg.sv
// Types, constants and the microcode table of the velocity PID core.
`default_nettype none
package vpt_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ACC_W  = 36;
  localparam int unsigned REG_W  = 31;
  localparam int unsigned PROD_W = 66;
  localparam int unsigned CFG_IDX_W = 8;

  // Anti-windup back-calculation gain, unsigned Q16.16
  localparam logic [WORD_W-1:0] WINDUP_GAIN_Q16 = 32'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_TIME   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DER_TIME   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PFILT_TIME = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DFILT_TIME = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 8'd7;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_SHL1, OP_SAT, OP_MOV, OP_CLAMP, OP_MUL16, OP_MUL17, OP_DIV
  } op_t;

  typedef enum logic [4:0] {
    S_E0, S_EL, S_EBL, S_PL, S_DL, S_DBL, S_VL, S_UL, S_DRL, S_WF,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5,
    S_GAIN, S_TI, S_TD, S_TP, S_TF, S_PER, S_OLIM, S_RLIM,
    S_SP, S_MS, S_WG, S_ZERO
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t a;
    sel_t b;
    sel_t dst;
  } uop_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic div_start;
    logic div_wb;
    logic load_out;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  localparam int unsigned UCODE_LEN = 64;
  localparam int unsigned PC_W = 6;

  function automatic uop_t mk(op_t op, sel_t a, sel_t b, sel_t dst);
    uop_t u;
    u.op = op; u.a = a; u.b = b; u.dst = dst;
    return u;
  endfunction

  function automatic uop_t ucode(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // error
      6'd0:  u = mk(OP_SUB,   S_SP,   S_MS,   S_T0);
      6'd1:  u = mk(OP_SAT,   S_T0,   S_ZERO, S_E0);
      // filtered proportional rate
      6'd2:  u = mk(OP_SUB,   S_E0,   S_EL,   S_T0);
      6'd3:  u = mk(OP_SAT,   S_T0,   S_ZERO, S_T0);
      6'd4:  u = mk(OP_MUL16, S_T0,   S_GAIN, S_T0);
      6'd5:  u = mk(OP_SHL1,  S_T0,   S_ZERO, S_T0);
      6'd6:  u = mk(OP_SAT,   S_T0,   S_ZERO, S_T0);
      6'd7:  u = mk(OP_SHL1,  S_TP,   S_ZERO, S_T1);
      6'd8:  u = mk(OP_SUB,   S_PER,  S_T1,   S_T2);
      6'd9:  u = mk(OP_SAT,   S_T2,   S_ZERO, S_T2);
      6'd10: u = mk(OP_MUL16, S_T2,   S_PL,   S_T2);
      6'd11: u = mk(OP_SUB,   S_T0,   S_T2,   S_T0);
      6'd12: u = mk(OP_SAT,   S_T0,   S_ZERO, S_T0);
      6'd13: u = mk(OP_ADD,   S_PER,  S_T1,   S_T1);
      6'd14: u = mk(OP_SAT,   S_T1,   S_ZERO, S_T1);
      6'd15: u = mk(OP_DIV,   S_T0,   S_T1,   S_T3);
      // integral rate
      6'd16: u = mk(OP_SUB,   S_E0,   S_WF,   S_T0);
      6'd17: u = mk(OP_SAT,   S_T0,   S_ZERO, S_T0);
      6'd18: u = mk(OP_MUL16, S_T0,   S_GAIN, S_T0);
      6'd19: u = mk(OP_DIV,   S_T0,   S_TI,   S_T4);
      // filtered derivative rate
      6'd20: u = mk(OP_MUL16, S_GAIN, S_TD,   S_T0);
      6'd21: u = mk(OP_SHL1,  S_EL,   S_ZERO, S_T1);
      6'd22: u = mk(OP_SUB,   S_E0,   S_T1,   S_T1);
      6'd23: u = mk(OP_ADD,   S_T1,   S_EBL,  S_T1);
      6'd24: u = mk(OP_SAT,   S_T1,   S_ZERO, S_T1);
      6'd25: u = mk(OP_MUL16, S_T0,   S_T1,   S_T0);
      6'd26: u = mk(OP_SHL1,  S_T0,   S_ZERO, S_T0);
      6'd27: u = mk(OP_SHL1,  S_T0,   S_ZERO, S_T0);
      6'd28: u = mk(OP_SAT,   S_T0,   S_ZERO, S_T0);
      6'd29: u = mk(OP_DIV,   S_T0,   S_PER,  S_T0);
      6'd30: u = mk(OP_MUL16, S_PER,  S_DL,   S_T1);
      6'd31: u = mk(OP_SHL1,  S_T1,   S_ZERO, S_T1);
      6'd32: u = mk(OP_SAT,   S_T1,   S_ZERO, S_T1);
      6'd33: u = mk(OP_SUB,   S_T0,   S_T1,   S_T0);
      6'd34: u = mk(OP_SHL1,  S_TF,   S_ZERO, S_T1);
      6'd35: u = mk(OP_SUB,   S_PER,  S_T1,   S_T2);
      6'd36: u = mk(OP_SAT,   S_T2,   S_ZERO, S_T2);
      6'd37: u = mk(OP_MUL16, S_T2,   S_DBL,  S_T2);
      6'd38: u = mk(OP_SUB,   S_T0,   S_T2,   S_T0);
      6'd39: u = mk(OP_SAT,   S_T0,   S_ZERO, S_T0);
      6'd40: u = mk(OP_ADD,   S_PER,  S_T1,   S_T1);
      6'd41: u = mk(OP_SAT,   S_T1,   S_ZERO, S_T1);
      6'd42: u = mk(OP_DIV,   S_T0,   S_T1,   S_T5);
      // history shift
      6'd43: u = mk(OP_MOV,   S_DL,   S_ZERO, S_DBL);
      6'd44: u = mk(OP_MOV,   S_T5,   S_ZERO, S_DL);
      6'd45: u = mk(OP_MOV,   S_EL,   S_ZERO, S_EBL);
      6'd46: u = mk(OP_MOV,   S_E0,   S_ZERO, S_EL);
      6'd47: u = mk(OP_MOV,   S_T3,   S_ZERO, S_PL);
      // rate sum and trapezoid step
      6'd48: u = mk(OP_ADD,   S_T3,   S_T4,   S_T0);
      6'd49: u = mk(OP_ADD,   S_T0,   S_T5,   S_T0);
      6'd50: u = mk(OP_SAT,   S_T0,   S_ZERO, S_T0);
      6'd51: u = mk(OP_ADD,   S_T0,   S_VL,   S_T1);
      6'd52: u = mk(OP_MUL17, S_T1,   S_PER,  S_T1);
      6'd53: u = mk(OP_MOV,   S_T0,   S_ZERO, S_VL);
      6'd54: u = mk(OP_ADD,   S_UL,   S_T1,   S_T1);
      6'd55: u = mk(OP_SAT,   S_T1,   S_ZERO, S_UL);
      // clamp, step limit, anti-windup
      6'd56: u = mk(OP_CLAMP, S_UL,   S_OLIM, S_T0);
      6'd57: u = mk(OP_SUB,   S_T0,   S_DRL,  S_T0);
      6'd58: u = mk(OP_CLAMP, S_T0,   S_RLIM, S_T0);
      6'd59: u = mk(OP_ADD,   S_DRL,  S_T0,   S_T0);
      6'd60: u = mk(OP_SAT,   S_T0,   S_ZERO, S_DRL);
      6'd61: u = mk(OP_SUB,   S_UL,   S_DRL,  S_T0);
      6'd62: u = mk(OP_SAT,   S_T0,   S_ZERO, S_T0);
      6'd63: u = mk(OP_MUL16, S_T0,   S_WG,   S_WF);
      default: u = mk(OP_MOV, S_ZERO, S_ZERO, S_T0);
    endcase
    return u;
  endfunction

  // Saturate to signed 32 bits, returned sign-extended to the accumulator width
  function automatic logic signed [ACC_W-1:0] sat32(logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sh7FFF_FFFF);
    lo = -PROD_W'(64'sh8000_0000);
    if (x > hi) return ACC_W'(hi);
    if (x < lo) return ACC_W'(lo);
    return x[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/vpt_div.sv
// Restoring divider: saturated Q16.16 quotient, one quotient bit per cycle.
`default_nettype none
module vpt_div
  import vpt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [WORD_W-1:0] dividend,
  input  wire logic        [WORD_W-1:0] divisor,
  output logic                          done,
  output logic signed [WORD_W-1:0]      quotient
);

  localparam int unsigned NUM_W = WORD_W + 1 + 16;
  localparam int unsigned CNT_W = 6;

  logic [NUM_W-1:0]      num_r;
  logic [WORD_W:0]       rem_r;
  logic [WORD_W-1:0]     den_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r, done_r, neg_r, zdiv_r;
  logic signed [WORD_W-1:0] zres_r;

  logic [WORD_W:0]       mag;
  logic [WORD_W:0]       rem_sh;
  logic                  fits;

  assign mag    = dividend[WORD_W-1] ? (WORD_W+1)'(-$signed({dividend[WORD_W-1], dividend}))
                                     : {1'b0, dividend};
  assign rem_sh = {rem_r[WORD_W-1:0], num_r[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r  <= dividend[WORD_W-1];
        den_r  <= divisor;
        rem_r  <= '0;
        num_r  <= {mag, 16'd0};
        cnt_r  <= CNT_W'(NUM_W);
        zdiv_r <= (divisor == '0);
        zres_r <= dividend[WORD_W-1] ? 32'sh8000_0000
                : (dividend == '0) ? 32'sd0 : 32'sh7FFF_FFFF;
        if (divisor == '0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= fits ? rem_sh - {1'b0, den_r} : rem_sh;
        num_r <= {num_r[NUM_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zdiv_r) begin
      quotient = zres_r;
    end else if (!neg_r) begin
      quotient = (num_r > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(num_r[WORD_W-1:0]);
    end else begin
      quotient = (num_r > NUM_W'(32'h8000_0000)) ? 32'sh8000_0000
               : $signed(WORD_W'(-num_r[WORD_W-1:0]));
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

FILE: sv/vpt_datapath.sv
// Datapath: operand select, ALU with one multiplier, divider, state and result registers.
`default_nettype none
module vpt_datapath
  import vpt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic [2*WORD_W-1:0]  in_word,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [WORD_W-1:0]    cfg_wdata,
  output logic [2*WORD_W-1:0]       out_word
);

  typedef logic signed [ACC_W-1:0] acc_t;

  // working and history registers
  acc_t e0_r, el_r, ebl_r, pl_r, dl_r, dbl_r, vl_r, ul_r, drl_r, wf_r;
  acc_t t0_r, t1_r, t2_r, t3_r, t4_r, t5_r;
  logic signed [WORD_W-1:0] sp_r, ms_r;
  logic [REG_W-1:0] gain_r, ti_r, td_r, tp_r, tf_r, per_r, olim_r, rlim_r;
  logic [2*WORD_W-1:0] out_r;

  acc_t opa, opb, res;
  logic signed [PROD_W-1:0] prod;
  logic signed [WORD_W-1:0] quo;
  logic div_done;

  function automatic acc_t pick(sel_t s,
      acc_t e0, acc_t el, acc_t ebl, acc_t pl, acc_t dl, acc_t dbl, acc_t vl, acc_t ul,
      acc_t drl, acc_t wf, acc_t t0, acc_t t1, acc_t t2, acc_t t3, acc_t t4, acc_t t5,
      acc_t gn, acc_t ti, acc_t td, acc_t tp, acc_t tf, acc_t per, acc_t ol, acc_t rl,
      acc_t sp, acc_t ms);
    case (s)
      S_E0:   return e0;
      S_EL:   return el;
      S_EBL:  return ebl;
      S_PL:   return pl;
      S_DL:   return dl;
      S_DBL:  return dbl;
      S_VL:   return vl;
      S_UL:   return ul;
      S_DRL:  return drl;
      S_WF:   return wf;
      S_T0:   return t0;
      S_T1:   return t1;
      S_T2:   return t2;
      S_T3:   return t3;
      S_T4:   return t4;
      S_T5:   return t5;
      S_GAIN: return gn;
      S_TI:   return ti;
      S_TD:   return td;
      S_TP:   return tp;
      S_TF:   return tf;
      S_PER:  return per;
      S_OLIM: return ol;
      S_RLIM: return rl;
      S_SP:   return sp;
      S_MS:   return ms;
      S_WG:   return ACC_W'(WINDUP_GAIN_Q16);
      default: return '0;
    endcase
  endfunction

  always_comb begin
    opa = pick(cmd.uop.a, e0_r, el_r, ebl_r, pl_r, dl_r, dbl_r, vl_r, ul_r, drl_r, wf_r,
               t0_r, t1_r, t2_r, t3_r, t4_r, t5_r,
               ACC_W'(gain_r), ACC_W'(ti_r), ACC_W'(td_r), ACC_W'(tp_r), ACC_W'(tf_r),
               ACC_W'(per_r), ACC_W'(olim_r), ACC_W'(rlim_r), ACC_W'(sp_r), ACC_W'(ms_r));
    opb = pick(cmd.uop.b, e0_r, el_r, ebl_r, pl_r, dl_r, dbl_r, vl_r, ul_r, drl_r, wf_r,
               t0_r, t1_r, t2_r, t3_r, t4_r, t5_r,
               ACC_W'(gain_r), ACC_W'(ti_r), ACC_W'(td_r), ACC_W'(tp_r), ACC_W'(tf_r),
               ACC_W'(per_r), ACC_W'(olim_r), ACC_W'(rlim_r), ACC_W'(sp_r), ACC_W'(ms_r));
  end

  // 34 x 32 signed product; the trapezoid step needs the extra bits on A
  assign prod = PROD_W'($signed(opa[33:0]) * $signed(opb[WORD_W-1:0]));

  always_comb begin
    case (cmd.uop.op)
      OP_ADD:   res = opa + opb;
      OP_SUB:   res = opa - opb;
      OP_SHL1:  res = opa <<< 1;
      OP_SAT:   res = sat32(PROD_W'(opa));
      OP_MOV:   res = opa;
      OP_CLAMP: res = (opa > opb) ? opb : (opa < -opb) ? -opb : opa;
      OP_MUL16: res = sat32((prod + PROD_W'(32768)) >>> 16);
      OP_MUL17: res = sat32((prod + PROD_W'(65536)) >>> 17);
      OP_DIV:   res = ACC_W'(quo);
      default:  res = '0;
    endcase
  end

  vpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (opa[WORD_W-1:0]),
    .divisor  (opb[WORD_W-1:0]),
    .done     (div_done),
    .quotient (quo)
  );

  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_r <= '0; el_r <= '0; ebl_r <= '0; pl_r <= '0; dl_r <= '0;
      dbl_r <= '0; vl_r <= '0; ul_r <= '0; drl_r <= '0; wf_r <= '0;
      gain_r <= 31'd65536;
      ti_r   <= 31'd6554;
      td_r   <= 31'd6554;
      tp_r   <= 31'd6554;
      tf_r   <= 31'd6554;
      per_r  <= 31'd65536;
      olim_r <= 31'd6553600;
      rlim_r <= 31'd65536;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GAIN:       gain_r <= cfg_wdata[REG_W-1:0];
          CFG_INT_TIME:   ti_r   <= cfg_wdata[REG_W-1:0];
          CFG_DER_TIME:   td_r   <= cfg_wdata[REG_W-1:0];
          CFG_PFILT_TIME: tp_r   <= cfg_wdata[REG_W-1:0];
          CFG_DFILT_TIME: tf_r   <= cfg_wdata[REG_W-1:0];
          CFG_PERIOD:     per_r  <= cfg_wdata[REG_W-1:0];
          CFG_OUT_LIMIT:  olim_r <= cfg_wdata[REG_W-1:0];
          CFG_RATE_LIMIT: rlim_r <= cfg_wdata[REG_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec || cmd.div_wb) begin
        case (cmd.uop.dst)
          S_E0:  e0_r  <= res;
          S_EL:  el_r  <= res;
          S_EBL: ebl_r <= res;
          S_PL:  pl_r  <= res;
          S_DL:  dl_r  <= res;
          S_DBL: dbl_r <= res;
          S_VL:  vl_r  <= res;
          S_UL:  ul_r  <= res;
          S_DRL: drl_r <= res;
          S_WF:  wf_r  <= res;
          default: ;
        endcase
      end
    end
  end

  // scratch, input and result registers carry no reset
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sp_r <= $signed(in_word[WORD_W-1:0]);
      ms_r <= $signed(in_word[2*WORD_W-1:WORD_W]);
    end
    if (cmd.exec || cmd.div_wb) begin
      case (cmd.uop.dst)
        S_T0: t0_r <= res;
        S_T1: t1_r <= res;
        S_T2: t2_r <= res;
        S_T3: t3_r <= res;
        S_T4: t4_r <= res;
        S_T5: t5_r <= res;
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      out_r <= {ul_r[WORD_W-1:0], drl_r[WORD_W-1:0]};
    end
  end

  assign out_word = out_r;

endmodule
`default_nettype wire

FILE: sv/vpt_ctrl.sv
// Controller: microcode sequencer and stream handshakes.
`default_nettype none
module vpt_ctrl
  import vpt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_DONE} state_t;

  state_t          state_r;
  logic [PC_W-1:0] pc_r;
  logic            out_valid_r;
  logic            last;

  assign last     = (pc_r == PC_W'(UCODE_LEN - 1));
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.uop       = ucode(pc_r);
    cmd.load_in   = in_valid && in_ready;
    cmd.exec      = (state_r == ST_RUN) && (cmd.uop.op != OP_DIV);
    cmd.div_start = (state_r == ST_RUN) && (cmd.uop.op == OP_DIV);
    cmd.div_wb    = (state_r == ST_DIV) && sts.div_done;
    cmd.load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cmd.load_in) begin
            pc_r    <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cmd.div_start) begin
            state_r <= ST_DIV;
          end else if (last) begin
            state_r <= ST_DONE;
          end else begin
            pc_r <= pc_r + 1'b1;
          end
        end
        ST_DIV: begin
          if (sts.div_done) begin
            if (last) begin
              state_r <= ST_DONE;
            end else begin
              pc_r    <= pc_r + 1'b1;
              state_r <= ST_RUN;
            end
          end
        end
        ST_DONE: begin
          if (cmd.load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: sv/velocity_pid_tustin_core.sv
// Top level of the velocity-form Tustin PID core.
`default_nettype none
// Velocity-form PID in signed Q16.16: each input word (setpoint, measurement)
// yields one output word (drive, unlimited_output). A 64-step microcode
// sequence runs on a shared ALU with one 34x32 multiplier. The four
// divisions go through a restoring divider at one quotient bit per cycle:
// each division step starts the divider, takes 49 quotient bits and writes
// the quotient back; a zero divisor skips the quotient bits and gives a
// saturated result (zero for a zero dividend). The other 60 steps run in
// the ALU. A new word is accepted once the previous one's result has
// moved into the output register, so a waiting result does not hold off the
// next word. Configuration writes are taken at any time but must be made
// only while the core is idle.
module velocity_pid_tustin_core
  import vpt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [2*WORD_W-1:0]    in_tdata,   // [31:0] setpoint, [63:32] measurement
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [2*WORD_W-1:0]         out_tdata,  // [31:0] drive, [63:32] unlimited_output
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [WORD_W-1:0]      cfg_data    // bits [30:0] used
);

  cmd_t cmd;
  sts_t sts;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  vpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vpt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_word  (out_tdata)
  );

endmodule
`default_nettype wire
